[hw/rtl/lres_pkg.sv]
package lres_pkg;

   // Field widths fixed by the interface
   localparam int IDX_W = 6;
   localparam int VAL_W = 16;
   localparam int SUM_W = 32;
   localparam int CNT_W = IDX_W + 1;
   localparam int KIND_W = 3;
   localparam int LEAK_W = 16;
   localparam int ADDR_W = 2 * IDX_W + 1;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_WIN  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRES = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BIAS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ELEM = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLR  = 3'd4;

   localparam logic [LEAK_W:0] LEAK_ONE = 17'd32768;
   localparam logic [13:0] TANH_END = 14'd16373;

   // One neuron's slot in the ring
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic signed [VAL_W-1:0] state;
      logic signed [VAL_W-1:0] nxt;
      logic signed [VAL_W-1:0] bias;
   } cell_data_type;

   typedef struct packed {
      logic shift;
      logic clr_state;
      logic bias_we;
   } cell_ctl_type;

   // Saturate a grown sum back to 32 bits
   function automatic logic signed [SUM_W-1:0] sat32(input logic signed [SUM_W+1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUM_W+1:SUM_W-1] != {3{v[SUM_W+1]}}) begin
         r = v[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

   // tanh(k/4) in unsigned Q0.14
   function automatic logic [13:0] tanh_rom(input logic [4:0] i);
      logic [13:0] r;
      case (i)
         5'd0:  r = 14'd0;
         5'd1:  r = 14'd4013;
         5'd2:  r = 14'd7571;
         5'd3:  r = 14'd10406;
         5'd4:  r = 14'd12478;
         5'd5:  r = 14'd13898;
         5'd6:  r = 14'd14830;
         5'd7:  r = 14'd15424;
         5'd8:  r = 14'd15795;
         5'd9:  r = 14'd16024;
         5'd10: r = 14'd16165;
         5'd11: r = 14'd16250;
         5'd12: r = 14'd16303;
         5'd13: r = 14'd16335;
         5'd14: r = 14'd16354;
         5'd15: r = 14'd16366;
         default: r = TANH_END;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/lres_ram.sv]
module lres_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/lres_cell.sv]
module lres_cell
   import lres_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  cell_data_type           nbr_in,
   input  logic signed [VAL_W-1:0] bias_value,
   output cell_data_type           data_out
);

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [VAL_W-1:0] state_ff;
   logic signed [VAL_W-1:0] nxt_ff;
   logic signed [VAL_W-1:0] bias_ff;

   // Take the neighbor's slot on shift; clear the state on request
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         state_ff <= '0;
      end else if (ctl.shift) begin
         sum_ff   <= nbr_in.sum;
         state_ff <= nbr_in.state;
      end else if (ctl.clr_state) begin
         state_ff <= '0;
      end
   end

   // Payload without reset
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         nxt_ff  <= nbr_in.nxt;
         bias_ff <= nbr_in.bias;
      end else if (ctl.bias_we) begin
         bias_ff <= bias_value;
      end
   end

   assign data_out.sum   = sum_ff;
   assign data_out.state = state_ff;
   assign data_out.nxt   = nxt_ff;
   assign data_out.bias  = bias_ff;

endmodule

[hw/rtl/lres_act.sv]
module lres_act
   import lres_pkg::*;
(
   input  logic                    clock,
   input  logic                    ld_x,
   input  logic                    ld_h,
   input  logic signed [SUM_W-1:0] sum,
   input  logic signed [VAL_W-1:0] bias,
   input  logic signed [VAL_W-1:0] state,
   input  logic [LEAK_W:0]         leak,
   output logic signed [VAL_W-1:0] new_state
);

   logic signed [SUM_W-1:0] x_ff, x_in;
   logic signed [VAL_W-1:0] h_ff, h_in;
   logic [SUM_W:0]          ax;
   logic [3:0]              seg;
   logic [21:0]             frac;
   logic [13:0]             t0, t1, dlt, y;
   logic [35:0]             prod;
   logic signed [LEAK_W+1:0] a_s, oma_s;
   logic signed [35:0]      mix;

   // Add the bias in Q.24
   always_comb begin
      x_in = sat32({{2{sum[SUM_W-1]}}, sum} +
                   {{6{bias[VAL_W-1]}}, bias, 12'b0});
   end

   // Interpolate tanh between table points
   always_comb begin
      ax    = x_ff[SUM_W-1] ? ((SUM_W+1)'(0) - {x_ff[SUM_W-1], x_ff}) : {1'b0, x_ff};
      seg   = ax[25:22];
      frac  = ax[21:0];
      t0    = tanh_rom({1'b0, seg});
      t1    = tanh_rom(5'({1'b0, seg}) + 5'd1);
      dlt   = t1 - t0;
      prod  = 36'(dlt) * 36'(frac) + 36'(1 << 21);
      if (ax[SUM_W:26] != '0) begin
         y = TANH_END;
      end else begin
         y = t0 + prod[35:22];
      end
      h_in = x_ff[SUM_W-1] ? (16'sd0 - $signed({2'b00, y})) : $signed({2'b00, y});
   end

   // Mix old state and activation by the leak factor
   always_comb begin
      a_s       = $signed({1'b0, leak});
      oma_s     = $signed({1'b0, LEAK_ONE}) - a_s;
      mix       = oma_s * state + a_s * h_ff + 36'sd16384;
      new_state = mix[30:15];
   end

   always_ff @(posedge clock) begin
      if (ld_x) begin
         x_ff <= x_in;
      end
      if (ld_h) begin
         h_ff <= h_in;
      end
   end

endmodule

[hw/rtl/leaky_reservoir_state_update.sv]
// Channel | Ports                                       | Direction
// req     | req_valid, req_stall, req_kind..req_last    | in
// rsp     | rsp_valid, rsp_stall, rsp_neuron..last_res  | out
// csr     | csr_we, csr_wdata (leak rate)               | in
//
// Weight, bias and clear beats are taken in the idle state. An input element
// runs one MAC per cycle as the neuron ring rotates past one shared
// multiplier. The last element then adds a start step, the reservoir sweep,
// the bias, tanh and leak steps, and the output beats, which rsp_stall can
// hold. Reset is synchronous and zeroes state and sums; weight and bias
// stores hold no reset value.
module leaky_reservoir_state_update
   import lres_pkg::*;
#(
   parameter int NEURONS = 32,
   parameter int INPUTS  = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [IDX_W-1:0]        req_row_index,
   input  logic [IDX_W-1:0]        req_col_index,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_neuron,
   output logic signed [VAL_W-1:0] rsp_state_value,
   output logic                    rsp_last_res,
   input  logic                    csr_we,
   input  logic [LEAK_W-1:0]       csr_wdata
);

   localparam int WIN_DEPTH  = INPUTS * NEURONS;
   localparam int WRES_DEPTH = NEURONS * NEURONS;
   localparam int WIN_AW  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int WRES_AW = (WRES_DEPTH > 1) ? $clog2(WRES_DEPTH) : 1;
   localparam logic [CNT_W-1:0] LAST_N = CNT_W'(NEURONS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC_IN, ST_RSTART, ST_RMAC, ST_FIN, ST_OUT
   } st_type;

   st_type st_ff, st_in;
   logic [CNT_W-1:0] k_ff, k_in, m_ff, m_in;
   logic [1:0]       fs_ff, fs_in;
   logic signed [VAL_W-1:0] u_ff, u_in, src_ff, src_in, srcn_ff, srcn_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic             last_ff, last_in;
   logic [LEAK_W-1:0] leak_ff;
   logic             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0] rsp_neuron_ff, rsp_neuron_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   cell_data_type ring [NEURONS];
   cell_data_type head, tail_in;
   logic          shift, clr_state, ld_x, ld_h;
   logic [NEURONS-1:0] bias_we;

   logic             win_we, wres_we;
   logic [ADDR_W-1:0] win_wfull, wres_wfull, win_rfull, wres_rfull;
   logic [VAL_W-1:0] win_rdata, wres_rdata;
   logic signed [SUM_W-1:0] p_in, p_res;
   logic signed [VAL_W-1:0] act_out;
   logic [LEAK_W:0]  leak_sat;
   logic             row_ok, col_ok;

   assign head = ring[0];

   // Weight stores
   lres_ram #(.WIDTH(VAL_W), .DEPTH(WIN_DEPTH)) u_win (
      .clock (clock),
      .we    (win_we),
      .waddr (win_wfull[WIN_AW-1:0]),
      .wdata (req_value),
      .raddr (win_rfull[WIN_AW-1:0]),
      .rdata (win_rdata)
   );

   lres_ram #(.WIDTH(VAL_W), .DEPTH(WRES_DEPTH)) u_wres (
      .clock (clock),
      .we    (wres_we),
      .waddr (wres_wfull[WRES_AW-1:0]),
      .wdata (req_value),
      .raddr (wres_rfull[WRES_AW-1:0]),
      .rdata (wres_rdata)
   );

   // Neuron ring: each cell takes its upper neighbor, the top one takes tail_in
   for (genvar i = 0; i < NEURONS; i++) begin : g_cell
      cell_ctl_type  ctl;
      cell_data_type nbr;
      assign ctl.shift     = shift;
      assign ctl.clr_state = clr_state;
      assign ctl.bias_we   = bias_we[i];
      if (i == NEURONS - 1) begin : g_tail
         assign nbr = tail_in;
      end else begin : g_mid
         assign nbr = ring[i+1];
      end
      lres_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .nbr_in     (nbr),
         .bias_value (req_value),
         .data_out   (ring[i])
      );
   end

   // Activation unit working on the head cell
   assign leak_sat = (leak_ff > LEAK_ONE[LEAK_W-1:0] && leak_ff[LEAK_W-1] && leak_ff != '0)
                     ? LEAK_ONE : {1'b0, leak_ff};

   lres_act u_act (
      .clock     (clock),
      .ld_x      (ld_x),
      .ld_h      (ld_h),
      .sum       (head.sum),
      .bias      (head.bias),
      .state     (head.state),
      .leak      (leak_sat),
      .new_state (act_out)
   );

   // Products against the head cell
   assign p_in  = u_ff * $signed(win_rdata);
   assign p_res = src_ff * $signed(wres_rdata);

   assign row_ok = (CNT_W'(req_row_index) < CNT_W'(INPUTS));
   assign col_ok = (CNT_W'(req_col_index) < CNT_W'(NEURONS));
   assign win_wfull  = ADDR_W'(req_row_index) * ADDR_W'(NEURONS) + ADDR_W'(req_col_index);
   assign wres_wfull = ADDR_W'(req_row_index) * ADDR_W'(NEURONS) + ADDR_W'(req_col_index);

   // Sequencer
   always_comb begin
      st_in        = st_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      fs_in        = fs_ff;
      u_in         = u_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      src_in       = src_ff;
      srcn_in      = srcn_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_neuron_in = rsp_neuron_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      tail_in      = head;
      shift        = 1'b0;
      clr_state    = 1'b0;
      bias_we      = '0;
      ld_x         = 1'b0;
      ld_h         = 1'b0;
      win_we       = 1'b0;
      wres_we      = 1'b0;
      win_rfull    = ADDR_W'(req_row_index) * ADDR_W'(NEURONS);
      wres_rfull   = '0;

      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_WIN: begin
                     win_we = row_ok && col_ok;
                  end
                  KIND_WRES: begin
                     wres_we = (CNT_W'(req_row_index) < CNT_W'(NEURONS)) && col_ok;
                  end
                  KIND_BIAS: begin
                     for (int i = 0; i < NEURONS; i++) begin
                        bias_we[i] = (CNT_W'(req_col_index) == CNT_W'(i));
                     end
                  end
                  KIND_CLR: begin
                     clr_state = 1'b1;
                  end
                  KIND_ELEM: begin
                     u_in    = req_value;
                     row_in  = req_row_index;
                     last_in = req_last;
                     k_in    = '0;
                     if (row_ok) begin
                        st_in = ST_MAC_IN;
                     end else if (req_last) begin
                        st_in = ST_RSTART;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Add u*Win to each sum, one neuron per cycle
         ST_MAC_IN: begin
            win_rfull   = ADDR_W'(row_ff) * ADDR_W'(NEURONS) + ADDR_W'(k_ff) + ADDR_W'(1);
            tail_in.sum = sat32({{2{head.sum[SUM_W-1]}}, head.sum} +
                                {{2{p_in[SUM_W-1]}}, p_in});
            shift = 1'b1;
            k_in  = k_ff + CNT_W'(1);
            if (k_ff == LAST_N) begin
               k_in  = '0;
               st_in = last_ff ? ST_RSTART : ST_IDLE;
            end
         end

         // Latch the first source state while the ring is aligned
         ST_RSTART: begin
            src_in = head.state;
            m_in   = '0;
            k_in   = '0;
            st_in  = ST_RMAC;
         end

         // Sweep source neuron m across all targets
         ST_RMAC: begin
            if (k_ff == LAST_N) begin
               wres_rfull = (ADDR_W'(m_ff) + ADDR_W'(1)) * ADDR_W'(NEURONS);
            end else begin
               wres_rfull = ADDR_W'(m_ff) * ADDR_W'(NEURONS) + ADDR_W'(k_ff) + ADDR_W'(1);
            end
            tail_in.sum = sat32({{2{head.sum[SUM_W-1]}}, head.sum} +
                                {{4{p_res[SUM_W-1]}}, p_res[SUM_W-1:2]});
            shift = 1'b1;
            k_in  = k_ff + CNT_W'(1);
            if (k_ff == m_ff + CNT_W'(1)) begin
               srcn_in = head.state;
            end
            if (k_ff == LAST_N) begin
               k_in   = '0;
               // Next source sits at the head right now when it is the top neuron
               src_in = (k_ff == m_ff + CNT_W'(1)) ? head.state : srcn_ff;
               m_in   = m_ff + CNT_W'(1);
               if (m_ff == LAST_N) begin
                  m_in  = '0;
                  fs_in = '0;
                  st_in = ST_FIN;
               end
            end
         end

         // Per neuron: add the bias, then take tanh, then mix by the leak
         ST_FIN: begin
            case (fs_ff)
               2'd0: begin
                  ld_x  = 1'b1;
                  fs_in = 2'd1;
               end
               2'd1: begin
                  ld_h  = 1'b1;
                  fs_in = 2'd2;
               end
               default: begin
                  tail_in.nxt = act_out;
                  shift = 1'b1;
                  fs_in = 2'd0;
                  k_in  = k_ff + CNT_W'(1);
                  if (k_ff == LAST_N) begin
                     k_in  = '0;
                     st_in = ST_OUT;
                  end
               end
            endcase
         end

         // Emit one beat per neuron, commit state and drop the sum
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_neuron_in = k_ff[IDX_W-1:0];
               rsp_value_in  = head.nxt;
               rsp_last_in   = (k_ff == LAST_N);
               tail_in.state = head.nxt;
               tail_in.sum   = '0;
               shift = 1'b1;
               k_in  = k_ff + CNT_W'(1);
               if (k_ff == LAST_N) begin
                  k_in  = '0;
                  st_in = ST_IDLE;
               end
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         k_ff         <= '0;
         m_ff         <= '0;
         fs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         leak_ff      <= LEAK_ONE[LEAK_W-1:0];
      end else begin
         st_ff        <= st_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            leak_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      u_ff          <= u_in;
      row_ff        <= row_in;
      last_ff       <= last_in;
      src_ff        <= src_in;
      srcn_ff       <= srcn_in;
      rsp_neuron_ff <= rsp_neuron_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall       = (st_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_neuron      = rsp_neuron_ff;
   assign rsp_state_value = rsp_value_ff;
   assign rsp_last_res    = rsp_last_ff;

endmodule

[hw/rtl/lres_checker.sv]
module lres_checker
   import lres_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [IDX_W-1:0]        rsp_neuron,
   input logic signed [VAL_W-1:0] rsp_state_value,
   input logic                    rsp_last_res
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_neuron) &&
      $stable(rsp_state_value) && $stable(rsp_last_res))
      else $error("stalled rsp beat changed");

   // Reset drops any result beat
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Take no input while an update is still emitting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_res |-> req_stall)
      else $error("input taken mid update");

   // Advance the neuron index by one per beat
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_res |=>
      !rsp_valid || rsp_neuron == $past(rsp_neuron) + 6'd1)
      else $error("neuron order broken");

endmodule

bind leaky_reservoir_state_update lres_checker u_lres_checker (.*);
